>>> hdl/cha_pkg.sv
// Shared types and constants for the chained hash accumulator.
// Transaction structs, entry layout, status codes and back-end states.
// No dependencies.
package cha_pkg;

    localparam int KEY_W            = 60;
    localparam int DIST_W           = 20;
    localparam int VIS_W            = 16;
    localparam int DSUM_W           = 32;
    localparam int COLL_W           = 16;
    localparam int ENTRY_COUNT      = 64;
    localparam int EIDX_W           = $clog2(ENTRY_COUNT);
    localparam int CNT_W            = $clog2(ENTRY_COUNT + 1);
    localparam int BUCKET_COUNT_DEF = 47;
    localparam int DIG_W            = 8;
    localparam int NDIG             = (KEY_W + DIG_W - 1) / DIG_W;
    localparam int QUEUE_DEPTH      = 2;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_RECORD = 1'b1;

    typedef enum logic [2:0] {
        ST_INSERTED = 3'd0,
        ST_COLLIDE  = 3'd1,
        ST_FULL     = 3'd2,
        ST_MATCHED  = 3'd3,
        ST_NO_MATCH = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_HEAD,
        BK_WALK,
        BK_DONE
    } t_back_state;

    typedef struct packed {
        logic              req_type;
        logic [KEY_W-1:0]  key_id;
        logic [DIST_W-1:0] trip_distance;
    } t_in_item;

    typedef struct packed {
        t_status           status;
        logic [EIDX_W-1:0] entry_index;
        logic [CNT_W-1:0]  match_count;
        logic [VIS_W-1:0]  visit_total;
        logic [DSUM_W-1:0] distance_total;
        logic [COLL_W-1:0] collision_total;
    } t_out_item;

    typedef struct packed {
        logic              link_vld;
        logic [EIDX_W-1:0] link;
        logic [KEY_W-1:0]  key;
        logic [VIS_W-1:0]  visits;
        logic [DSUM_W-1:0] dsum;
    } t_entry;

endpackage

>>> hdl/cha_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module cha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

>>> hdl/cha_front.sv
// Front end: accepts request transactions and reduces the key modulo the bucket
// count, one key byte per cycle. Depends on cha_pkg.
module cha_front #(
    parameter int BUCKET_COUNT = cha_pkg::BUCKET_COUNT_DEF,
    localparam int BKT_W       = $clog2(BUCKET_COUNT)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  cha_pkg::t_in_item   i_in_data,
    output logic                o_q_valid,
    input  logic                i_q_stall,
    output cha_pkg::t_in_item   o_q_item,
    output logic [BKT_W-1:0]    o_q_bucket
);

    localparam int PAD_W  = cha_pkg::NDIG * cha_pkg::DIG_W;
    localparam int DCNT_W = (cha_pkg::NDIG > 1) ? $clog2(cha_pkg::NDIG) : 1;
    localparam logic [BKT_W:0] BKT_DIV = (BKT_W + 1)'(BUCKET_COUNT);

    logic                r_busy;
    logic                r_done;
    logic [DCNT_W-1:0]   r_dig;
    logic [PAD_W-1:0]    r_shift;
    logic [BKT_W-1:0]    r_rem;
    logic [BKT_W-1:0]    n_rem;
    cha_pkg::t_in_item   r_item;
    logic                w_accept;
    logic                w_push;

    assign o_in_stall = r_busy && !(r_done && !i_q_stall);
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_push     = r_done && !i_q_stall;
    assign o_q_valid  = r_done;
    assign o_q_item   = r_item;
    assign o_q_bucket = r_rem;

    // restoring reduction, MSB first
    always_comb begin
        logic [BKT_W:0]   w_t;
        logic [BKT_W-1:0] w_r;
        w_r = r_rem;
        w_t = '0;
        for (int i = 0; i < cha_pkg::DIG_W; i++) begin
            w_t = {w_r, r_shift[PAD_W-1-i]};
            if (w_t >= BKT_DIV) begin
                w_t = w_t - BKT_DIV;
            end
            w_r = w_t[BKT_W-1:0];
        end
        n_rem = w_r;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            if (w_accept) begin
                r_busy <= 1'b1;
                r_done <= 1'b0;
            end else if (w_push) begin
                r_busy <= 1'b0;
                r_done <= 1'b0;
            end else if (r_busy && !r_done && r_dig == '0) begin
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item  <= i_in_data;
            r_shift <= PAD_W'(i_in_data.key_id);
            r_rem   <= '0;
            r_dig   <= DCNT_W'(cha_pkg::NDIG - 1);
        end else if (r_busy && !r_done) begin
            r_shift <= r_shift << cha_pkg::DIG_W;
            r_rem   <= n_rem;
            r_dig   <= r_dig - DCNT_W'(1);
        end
    end

endmodule

>>> hdl/cha_queue.sv
// Short queue between the hashing front end and the table back end.
// Depends on cha_pkg.
module cha_queue #(
    parameter int BUCKET_COUNT = cha_pkg::BUCKET_COUNT_DEF,
    localparam int BKT_W       = $clog2(BUCKET_COUNT)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  cha_pkg::t_in_item   i_item,
    input  logic [BKT_W-1:0]    i_bucket,
    output logic                o_valid,
    input  logic                i_pop,
    output cha_pkg::t_in_item   o_item,
    output logic [BKT_W-1:0]    o_bucket
);

    localparam int PTR_W = (cha_pkg::QUEUE_DEPTH > 1) ? $clog2(cha_pkg::QUEUE_DEPTH) : 1;
    localparam int QCNT_W = $clog2(cha_pkg::QUEUE_DEPTH + 1);

    cha_pkg::t_in_item r_item [cha_pkg::QUEUE_DEPTH];
    logic [BKT_W-1:0]  r_bkt  [cha_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_wp;
    logic [PTR_W-1:0]  r_rp;
    logic [QCNT_W-1:0] r_cnt;
    logic              w_push;
    logic              w_pop;

    assign o_stall  = (r_cnt == QCNT_W'(cha_pkg::QUEUE_DEPTH));
    assign o_valid  = (r_cnt != '0);
    assign w_push   = i_valid && !o_stall;
    assign w_pop    = i_pop && o_valid;
    assign o_item   = r_item[r_rp];
    assign o_bucket = r_bkt[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= (r_wp == PTR_W'(cha_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wp + PTR_W'(1);
            end
            if (w_pop) begin
                r_rp <= (r_rp == PTR_W'(cha_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rp + PTR_W'(1);
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + QCNT_W'(1);
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_item[r_wp] <= i_item;
            r_bkt[r_wp]  <= i_bucket;
        end
    end

endmodule

>>> hdl/cha_back.sv
// Back end: bucket heads and entry store, insert and chain walk sequencer,
// output register. Depends on cha_pkg and cha_ram.
module cha_back #(
    parameter int BUCKET_COUNT = cha_pkg::BUCKET_COUNT_DEF,
    localparam int BKT_W       = $clog2(BUCKET_COUNT)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_valid,
    output logic                o_q_pop,
    input  cha_pkg::t_in_item   i_q_item,
    input  logic [BKT_W-1:0]    i_q_bucket,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output cha_pkg::t_out_item  o_out_data
);

    localparam int EIDX_W = cha_pkg::EIDX_W;
    localparam int CNT_W  = cha_pkg::CNT_W;
    localparam int ENT_W  = $bits(cha_pkg::t_entry);

    cha_pkg::t_back_state       r_state;
    cha_pkg::t_back_state       n_state;
    cha_pkg::t_in_item          r_cur;
    logic [BKT_W-1:0]           r_bkt;
    logic [BUCKET_COUNT-1:0]    r_head_vld;
    logic [CNT_W-1:0]           r_used;
    logic [cha_pkg::COLL_W-1:0] r_coll;
    logic [CNT_W-1:0]           r_match;
    logic [EIDX_W-1:0]          r_idx;
    logic [EIDX_W-1:0]          r_walk;
    logic [cha_pkg::VIS_W-1:0]  r_vis;
    logic [cha_pkg::DSUM_W-1:0] r_dst;
    cha_pkg::t_status           r_status;
    logic                       r_out_valid;
    cha_pkg::t_out_item         r_out;

    logic [EIDX_W-1:0]          w_head_rdata;
    logic                       w_head_we;
    logic [ENT_W-1:0]           w_ent_rdv;
    cha_pkg::t_entry            w_ent_rd;
    cha_pkg::t_entry            w_ent_wdata;
    logic                       w_ent_we;
    logic [EIDX_W-1:0]          w_ent_waddr;
    logic [EIDX_W-1:0]          w_ent_raddr;
    logic                       w_full;
    logic                       w_hit;
    logic [cha_pkg::VIS_W-1:0]  w_new_vis;
    logic [cha_pkg::DSUM_W:0]   w_dsum;
    logic [cha_pkg::DSUM_W-1:0] w_new_dst;
    logic                       w_out_load;

    assign w_ent_rd  = cha_pkg::t_entry'(w_ent_rdv);
    assign w_full    = (r_used == CNT_W'(cha_pkg::ENTRY_COUNT));
    assign w_hit     = (w_ent_rd.key == r_cur.key_id);
    assign w_new_vis = (w_ent_rd.visits == '1) ? w_ent_rd.visits
                                               : w_ent_rd.visits + cha_pkg::VIS_W'(1);
    assign w_dsum    = {1'b0, w_ent_rd.dsum} + (cha_pkg::DSUM_W + 1)'(r_cur.trip_distance);
    assign w_new_dst = w_dsum[cha_pkg::DSUM_W] ? '1 : w_dsum[cha_pkg::DSUM_W-1:0];

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    cha_ram #(
        .WIDTH (EIDX_W),
        .DEPTH (BUCKET_COUNT)
    ) u_head_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_head_we),
        .i_wr_addr (r_bkt),
        .i_wr_data (r_used[EIDX_W-1:0]),
        .i_rd_addr (i_q_bucket),
        .o_rd_data (w_head_rdata)
    );

    cha_ram #(
        .WIDTH (ENT_W),
        .DEPTH (cha_pkg::ENTRY_COUNT)
    ) u_entry_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_ent_we),
        .i_wr_addr (w_ent_waddr),
        .i_wr_data (w_ent_wdata),
        .i_rd_addr (w_ent_raddr),
        .o_rd_data (w_ent_rdv)
    );

    always_comb begin
        n_state     = r_state;
        o_q_pop     = 1'b0;
        w_head_we   = 1'b0;
        w_ent_we    = 1'b0;
        w_ent_waddr = r_walk;
        w_ent_wdata = w_ent_rd;
        w_ent_raddr = w_head_rdata;
        w_out_load  = 1'b0;
        case (r_state)
            cha_pkg::BK_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_state = cha_pkg::BK_HEAD;
                end
            end
            cha_pkg::BK_HEAD: begin
                if (r_cur.req_type == cha_pkg::REQ_INSERT) begin
                    if (!w_full) begin
                        w_head_we            = 1'b1;
                        w_ent_we             = 1'b1;
                        w_ent_waddr          = r_used[EIDX_W-1:0];
                        w_ent_wdata.link_vld = r_head_vld[r_bkt];
                        w_ent_wdata.link     = w_head_rdata;
                        w_ent_wdata.key      = r_cur.key_id;
                        w_ent_wdata.visits   = '0;
                        w_ent_wdata.dsum     = '0;
                    end
                    n_state = cha_pkg::BK_DONE;
                end else if (r_head_vld[r_bkt]) begin
                    n_state = cha_pkg::BK_WALK;
                end else begin
                    n_state = cha_pkg::BK_DONE;
                end
            end
            cha_pkg::BK_WALK: begin
                w_ent_raddr = w_ent_rd.link;
                if (w_hit) begin
                    w_ent_we           = 1'b1;
                    w_ent_wdata.visits = w_new_vis;
                    w_ent_wdata.dsum   = w_new_dst;
                end
                if (!w_ent_rd.link_vld) begin
                    n_state = cha_pkg::BK_DONE;
                end
            end
            cha_pkg::BK_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    w_out_load = 1'b1;
                    n_state    = cha_pkg::BK_IDLE;
                end
            end
            default: begin
                n_state = cha_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= cha_pkg::BK_IDLE;
            r_head_vld  <= '0;
            r_used      <= '0;
            r_coll      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (w_head_we) begin
                r_head_vld[r_bkt] <= 1'b1;
                r_used            <= r_used + CNT_W'(1);
                if (r_head_vld[r_bkt] && r_coll != '1) begin
                    r_coll <= r_coll + cha_pkg::COLL_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_cur   <= i_q_item;
            r_bkt   <= i_q_bucket;
            r_match <= '0;
            r_idx   <= '0;
            r_vis   <= '0;
            r_dst   <= '0;
        end
        if (r_state == cha_pkg::BK_HEAD) begin
            r_walk <= w_head_rdata;
            if (r_cur.req_type == cha_pkg::REQ_INSERT) begin
                if (w_full) begin
                    r_status <= cha_pkg::ST_FULL;
                end else begin
                    r_idx    <= r_used[EIDX_W-1:0];
                    r_status <= r_head_vld[r_bkt] ? cha_pkg::ST_COLLIDE
                                                  : cha_pkg::ST_INSERTED;
                end
            end else begin
                r_status <= cha_pkg::ST_NO_MATCH;
            end
        end
        if (r_state == cha_pkg::BK_WALK) begin
            r_walk <= w_ent_rd.link;
            if (w_hit) begin
                r_match  <= r_match + CNT_W'(1);
                r_idx    <= r_walk;
                r_vis    <= w_new_vis;
                r_dst    <= w_new_dst;
                r_status <= cha_pkg::ST_MATCHED;
            end
        end
        if (w_out_load) begin
            r_out.status          <= r_status;
            r_out.entry_index     <= r_idx;
            r_out.match_count     <= r_match;
            r_out.visit_total     <= r_vis;
            r_out.distance_total  <= r_dst;
            r_out.collision_total <= r_coll;
        end
    end

endmodule

>>> hdl/chained_hash_accumulator.sv
// Top level of the chained hash accumulator: hashing front end, queue, table back end.
// Depends on cha_pkg, cha_front, cha_queue, cha_back.
//
//   channel  | direction | handshake                 | payload
//   ---------+-----------+---------------------------+----------------------------
//   in       | input     | i_in_valid / o_in_stall   | i_in_data  (t_in_item)
//   out      | output    | o_out_valid / i_out_stall | o_out_data (t_out_item)
//
// Front end: one key byte per cycle through the modulo reducer, then a hand-off to the
//   queue; it takes no new transaction until the previous one has been handed off.
// Back end: idle, head and done states, plus the walk state for a record on a non-empty
//   bucket (one entry RAM read per link). The slower of the two ends sets the sustained rate.
// Reset clears bucket valid bits, fill count and collision count at once; no clearing pass.
// A two-deep queue lets the front keep hashing while the back or the output is stalled.
module chained_hash_accumulator #(
    parameter int BUCKET_COUNT = cha_pkg::BUCKET_COUNT_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  cha_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output cha_pkg::t_out_item o_out_data
);

    localparam int BKT_W = $clog2(BUCKET_COUNT);

    logic              w_fq_valid;
    logic              w_fq_stall;
    cha_pkg::t_in_item w_fq_item;
    logic [BKT_W-1:0]  w_fq_bucket;
    logic              w_q_valid;
    logic              w_q_pop;
    cha_pkg::t_in_item w_q_item;
    logic [BKT_W-1:0]  w_q_bucket;

    cha_front #(
        .BUCKET_COUNT (BUCKET_COUNT)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_q_valid  (w_fq_valid),
        .i_q_stall  (w_fq_stall),
        .o_q_item   (w_fq_item),
        .o_q_bucket (w_fq_bucket)
    );

    cha_queue #(
        .BUCKET_COUNT (BUCKET_COUNT)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_fq_valid),
        .o_stall  (w_fq_stall),
        .i_item   (w_fq_item),
        .i_bucket (w_fq_bucket),
        .o_valid  (w_q_valid),
        .i_pop    (w_q_pop),
        .o_item   (w_q_item),
        .o_bucket (w_q_bucket)
    );

    cha_back #(
        .BUCKET_COUNT (BUCKET_COUNT)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (w_q_valid),
        .o_q_pop     (w_q_pop),
        .i_q_item    (w_q_item),
        .i_q_bucket  (w_q_bucket),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

`ifndef SYNTHESIS
    a_bucket_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fq_valid |-> (int'(w_fq_bucket) < BUCKET_COUNT))
        else $error("hashed bucket out of range");

    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_pop |-> w_q_valid)
        else $error("back end popped an empty queue");

    a_pop_spacing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_pop |=> !w_q_pop)
        else $error("back end popped on consecutive cycles");

    a_match_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_out_data.status == cha_pkg::ST_MATCHED)
                         == (o_out_data.match_count != '0)))
        else $error("status and match count disagree");
`endif

endmodule

>>> bench/tb_top.sv
// Testbench for chained_hash_accumulator: directed, repeated-hit, backpressure, full-table
// and random transactions, with an in-bench table model predicting every result.
// Depends on cha_pkg and the chained_hash_accumulator RTL.
module tb_top;

    localparam int KEY_W       = cha_pkg::KEY_W;
    localparam int DIST_W      = cha_pkg::DIST_W;
    localparam int VIS_W       = cha_pkg::VIS_W;
    localparam int DSUM_W      = cha_pkg::DSUM_W;
    localparam int COLL_W      = cha_pkg::COLL_W;
    localparam int EIDX_W      = cha_pkg::EIDX_W;
    localparam int ENTRY_COUNT = cha_pkg::ENTRY_COUNT;
    localparam int BUCKETS     = cha_pkg::BUCKET_COUNT_DEF;
    localparam int HOT_BUCKET  = 5;
    localparam int QUIET_MAX   = 3000;
    localparam int HOLD_LEN    = 300;
    localparam int REPEAT_RUNS = 40;
    localparam logic [KEY_W-1:0]  KEY_MAX  = '1;
    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    cha_pkg::t_in_item  i_in_data;
    logic               o_out_valid;
    logic               i_out_stall;
    cha_pkg::t_out_item o_out_data;

    chained_hash_accumulator #(
        .BUCKET_COUNT(BUCKETS)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data)
    );

    always #6 i_clk = ~i_clk;

    // table model
    logic [EIDX_W-1:0] head_tab  [BUCKETS];
    bit                head_vld  [BUCKETS];
    logic [EIDX_W-1:0] link_tab  [ENTRY_COUNT];
    bit                link_vld  [ENTRY_COUNT];
    logic [KEY_W-1:0]  key_tab   [ENTRY_COUNT];
    logic [VIS_W-1:0]  visit_tab [ENTRY_COUNT];
    logic [DSUM_W-1:0] dist_tab  [ENTRY_COUNT];
    int                table_fill;
    logic [COLL_W-1:0] coll_cnt;

    cha_pkg::t_out_item pending_results[$];
    int                 mismatch_count;
    int                 sent_count;
    int                 checked_count;
    int                 match_hits;
    bit                 idle_en;
    int                 out_hold_len;

    function automatic cha_pkg::t_out_item apply_request(input cha_pkg::t_in_item req);
        cha_pkg::t_out_item res;
        int                 b;
        int                 idx;
        int                 steps;
        bit                 more;
        logic [DSUM_W:0]    sum;
        res = '0;
        b = int'(req.key_id % BUCKETS);
        if (req.req_type == cha_pkg::REQ_INSERT) begin
            if (table_fill >= ENTRY_COUNT) begin
                res.status = cha_pkg::ST_FULL;
            end else begin
                key_tab[table_fill]   = req.key_id;
                visit_tab[table_fill] = '0;
                dist_tab[table_fill]  = '0;
                if (head_vld[b]) begin
                    res.status = cha_pkg::ST_COLLIDE;
                    if (coll_cnt != '1) coll_cnt++;
                end else begin
                    res.status = cha_pkg::ST_INSERTED;
                end
                link_tab[table_fill] = head_tab[b];
                link_vld[table_fill] = head_vld[b];
                head_tab[b] = EIDX_W'(table_fill);
                head_vld[b] = 1'b1;
                res.entry_index = EIDX_W'(table_fill);
                table_fill++;
            end
        end else begin
            more  = head_vld[b];
            idx   = int'(head_tab[b]);
            steps = 0;
            while (more && steps < ENTRY_COUNT) begin
                if (key_tab[idx] == req.key_id) begin
                    sum = {1'b0, dist_tab[idx]} + (DSUM_W + 1)'(req.trip_distance);
                    if (visit_tab[idx] != '1) visit_tab[idx]++;
                    dist_tab[idx] = sum[DSUM_W] ? '1 : sum[DSUM_W-1:0];
                    res.match_count++;
                    res.entry_index    = EIDX_W'(idx);
                    res.visit_total    = visit_tab[idx];
                    res.distance_total = dist_tab[idx];
                end
                more = link_vld[idx];
                idx  = int'(link_tab[idx]);
                steps++;
            end
            res.status = (res.match_count != 0) ? cha_pkg::ST_MATCHED : cha_pkg::ST_NO_MATCH;
            if (res.match_count != 0) match_hits++;
        end
        res.collision_total = coll_cnt;
        return res;
    endfunction

    function automatic logic [KEY_W-1:0] rand_key();
        logic [63:0] r;
        r = {$urandom(), $urandom()};
        return r[KEY_W-1:0];
    endfunction

    function automatic logic [KEY_W-1:0] hot_key();
        return rand_key() / BUCKETS * BUCKETS + HOT_BUCKET;
    endfunction

    function automatic logic [DIST_W-1:0] rand_distance();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return DIST_MAX;
            default: return DIST_W'($urandom_range(0, (1 << DIST_W) - 1));
        endcase
    endfunction

    // Sender: valid stays up between back-to-back transactions.
    task automatic send_request(input logic kind, input logic [KEY_W-1:0] key,
                                input logic [DIST_W-1:0] trip);
        cha_pkg::t_in_item item;
        item.req_type      = kind;
        item.key_id        = key;
        item.trip_distance = trip;
        if (idle_en && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        do @(posedge i_clk); while (o_in_stall);
        pending_results = {pending_results, apply_request(item)};
        sent_count++;
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic check_field(input string name, input longint unsigned want,
                               input longint unsigned got);
        if (want !== got) begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    task automatic test_directed_basics();
        idle_en = 1'b1;
        send_request(cha_pkg::REQ_RECORD, '0, 5);            // empty table
        send_request(cha_pkg::REQ_INSERT, '0, DIST_MAX);     // distance ignored on insert
        send_request(cha_pkg::REQ_INSERT, KEY_MAX, '0);
        send_request(cha_pkg::REQ_INSERT, 47, '0);           // same bucket as key 0
        send_request(cha_pkg::REQ_INSERT, '0, '0);           // duplicate key
        send_request(cha_pkg::REQ_RECORD, '0, DIST_MAX);     // two matches on one chain
        send_request(cha_pkg::REQ_RECORD, '0, DIST_MAX);
        send_request(cha_pkg::REQ_RECORD, 47, '0);
        send_request(cha_pkg::REQ_RECORD, 94, 1);            // walks whole chain, no match
        send_request(cha_pkg::REQ_RECORD, KEY_MAX, DIST_MAX);
        send_request(cha_pkg::REQ_RECORD, 1, '0);            // empty bucket
        send_request(cha_pkg::REQ_INSERT, HOT_BUCKET, '0);
        send_request(cha_pkg::REQ_RECORD, HOT_BUCKET, 20'h5A5A5);
        wait_drained();
    endtask

    // Back-to-back hits on one entry with the largest distance.
    task automatic test_repeat_hits();
        idle_en = 1'b0;
        repeat (REPEAT_RUNS) send_request(cha_pkg::REQ_RECORD, KEY_MAX, DIST_MAX);
        wait_drained();
    endtask

    task automatic test_backpressure();
        idle_en = 1'b0;
        out_hold_len = HOLD_LEN;
        repeat (12) send_request(cha_pkg::REQ_RECORD,
                                 key_tab[$urandom_range(0, table_fill - 1)],
                                 rand_distance());
        wait_drained();
    endtask

    task automatic test_random_traffic(input int count, input bit with_idle);
        int pick;
        idle_en = with_idle;
        repeat (count) begin
            pick = $urandom_range(0, 99);
            if (pick < ((table_fill < ENTRY_COUNT) ? 15 : 3)) begin
                case ($urandom_range(0, 3))
                    0, 1: send_request(cha_pkg::REQ_INSERT, hot_key(), rand_distance());
                    2: send_request(cha_pkg::REQ_INSERT,
                                    key_tab[$urandom_range(0, table_fill - 1)],
                                    rand_distance());
                    default: send_request(cha_pkg::REQ_INSERT, rand_key(), rand_distance());
                endcase
            end else if (pick < 85) begin
                send_request(cha_pkg::REQ_RECORD, key_tab[$urandom_range(0, table_fill - 1)],
                             rand_distance());
            end else if (pick < 93) begin
                send_request(cha_pkg::REQ_RECORD, hot_key(), rand_distance());
            end else begin
                send_request(cha_pkg::REQ_RECORD, rand_key(), rand_distance());
            end
        end
        wait_drained();
    endtask

    task automatic test_full_table();
        idle_en = 1'b1;
        while (table_fill < ENTRY_COUNT) begin
            send_request(cha_pkg::REQ_INSERT, rand_key(), rand_distance());
        end
        send_request(cha_pkg::REQ_INSERT, '0, DIST_MAX);
        send_request(cha_pkg::REQ_INSERT, KEY_MAX, '0);
        send_request(cha_pkg::REQ_INSERT, rand_key(), rand_distance());
        send_request(cha_pkg::REQ_RECORD, '0, DIST_MAX);
        send_request(cha_pkg::REQ_RECORD, key_tab[ENTRY_COUNT - 1], 1);
        wait_drained();
    endtask

    initial begin : main_seq
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_data  <= '0;
        for (int b = 0; b < BUCKETS; b++) begin
            head_tab[b] = '0;
            head_vld[b] = 1'b0;
        end
        for (int e = 0; e < ENTRY_COUNT; e++) begin
            link_tab[e]  = '0;
            link_vld[e]  = 1'b0;
            key_tab[e]   = '0;
            visit_tab[e] = '0;
            dist_tab[e]  = '0;
        end
        table_fill     = 0;
        coll_cnt       = '0;
        mismatch_count = 0;
        sent_count     = 0;
        checked_count  = 0;
        match_hits     = 0;
        idle_en        = 1'b0;
        out_hold_len   = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_basics();
        test_repeat_hits();
        test_backpressure();
        test_random_traffic(560, 1'b1);
        test_full_table();
        test_random_traffic(120, 1'b0);

        repeat (20) @(posedge i_clk);
        $display("%0d transactions sent, %0d results checked, %0d record hits",
                 sent_count, checked_count, match_hits);
        $display("table filled to %0d entries with %0d collisions", table_fill, coll_cnt);
        if (mismatch_count == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

    initial begin : out_stall_gen
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (out_hold_len > 0) begin
                i_out_stall <= 1'b1;
                repeat (out_hold_len) @(posedge i_clk);
                out_hold_len = 0;
                i_out_stall <= 1'b0;
            end else if (idle_en && $urandom_range(0, 11) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 17)) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    initial begin : result_checker
        cha_pkg::t_out_item want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) begin
                checked_count++;
                if (pending_results.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: result with no transaction pending, actual %p",
                             $time, o_out_data);
                end else begin
                    want = pending_results.pop_front();
                    check_field("status", want.status, o_out_data.status);
                    check_field("entry_index", want.entry_index, o_out_data.entry_index);
                    check_field("match_count", want.match_count, o_out_data.match_count);
                    check_field("visit_total", want.visit_total, o_out_data.visit_total);
                    check_field("distance_total", want.distance_total,
                                o_out_data.distance_total);
                    check_field("collision_total", want.collision_total,
                                o_out_data.collision_total);
                end
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_MAX) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) quiet = 0;
            else quiet++;
        end
        $display("%0t: no transaction for %0d cycles", $time, QUIET_MAX);
        $display("tb_top failed");
        $finish;
    end

endmodule

>>> sim.f
hdl/cha_pkg.sv
hdl/cha_ram.sv
hdl/cha_front.sv
hdl/cha_queue.sv
hdl/cha_back.sv
hdl/chained_hash_accumulator.sv
bench/tb_top.sv
